FILE: rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants shared by the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int INDEX_BITS = 16;
    localparam int LEN_BITS   = INDEX_BITS + 1;
    localparam int FREE_SLOTS_DEFAULT = 64;
    localparam logic [LEN_BITS-1:0] INDEX_SPACE = {1'b1, {INDEX_BITS{1'b0}}};
    localparam logic [LEN_BITS-1:0] CAP_RESET   = LEN_BITS'(512);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [LEN_BITS-1:0]   range_length;
        logic [INDEX_BITS-1:0] range_base;
    } t_in_beat;

    typedef struct packed {
        logic [INDEX_BITS-1:0] granted_base;
        logic [LEN_BITS-1:0]   granted_length;
        logic [1:0]            status;
    } t_out_beat;

    typedef struct packed {
        logic [INDEX_BITS-1:0] base;
        logic [LEN_BITS-1:0]   len;
    } t_entry;

endpackage

FILE: rtl/core/first_fit_range_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit
// First-fit range allocator with a sorted, coalescing free table.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): mode 0 allocates range_length indices,
// mode 1 frees range_length indices at range_base. Each request beat
// produces exactly one result beat: granted base, granted length, status.
// Allocation takes the first table entry that is long enough, whole;
// otherwise it bumps the pointer within the capacity register.
// Sequencing: the sequencer reads one table entry per step (S_RD, then S_EV)
// through the single read port of the table memory, so a request costs
// one step per entry scanned, plus one read/write step per entry moved
// when an entry is removed or inserted, plus decision and output. An
// empty table skips the scan; one request is in flight at a time.
// Result sits in an output register; a new request is taken while it
// waits, but the next result stalls until the receiver takes the first.
// Reset (synchronous, active low) empties the table, clears the bump
// pointer and loads capacity 512; no clearing pass is needed.
// The user must write capacity through i_cfg_we/i_cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_unit #(
    parameter int FREE_SLOTS = ffra_pkg::FREE_SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffra_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffra_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [ffra_pkg::LEN_BITS-1:0] i_cfg_data
);

    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    ffra_pkg::t_entry mem_wdata;
    ffra_pkg::t_entry mem_rdata;

    ffra_ctrl #(.FREE_SLOTS(FREE_SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ffra_table #(.FREE_SLOTS(FREE_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: rtl/core/ffra_table.sv
// ----------------------------------------------------------------------------
// ffra_table
// Free table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffra_table #(
    parameter int FREE_SLOTS = ffra_pkg::FREE_SLOTS_DEFAULT,
    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ffra_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output ffra_pkg::t_entry o_rdata
);

    ffra_pkg::t_entry mem [FREE_SLOTS];
    ffra_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Request sequencer: scans the free table, merges, shifts entries, and
// holds the bump pointer, the capacity register and the result register.
// ----------------------------------------------------------------------------
module ffra_ctrl #(
    parameter int FREE_SLOTS = ffra_pkg::FREE_SLOTS_DEFAULT,
    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1,
    localparam int CW = $clog2(FREE_SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffra_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffra_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_we,
    input  logic [ffra_pkg::LEN_BITS-1:0] i_cfg_data,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output ffra_pkg::t_entry    o_mem_wdata,
    output logic [AW-1:0]       o_mem_raddr,
    input  ffra_pkg::t_entry    i_mem_rdata
);

    localparam int LB = ffra_pkg::LEN_BITS;
    localparam int IB = ffra_pkg::INDEX_BITS;
    localparam logic [CW-1:0] SLOTS = CW'(FREE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EV, S_DEC, S_RM_RD, S_RM_WR, S_INS_RD, S_INS_WR, S_DONE
    } t_state;

    t_state              r_state;
    logic                r_mode;
    logic [LB-1:0]       r_len;
    logic [IB-1:0]       r_base;
    logic [CW-1:0]       r_count;
    logic [LB-1:0]       r_bump;
    logic [LB-1:0]       r_cap;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_j;
    logic                r_have_prev;
    logic                r_have_next;
    ffra_pkg::t_entry    r_prev;
    ffra_pkg::t_entry    r_next;
    logic                r_out_valid;
    ffra_pkg::t_out_beat r_out;
    ffra_pkg::t_out_beat r_res;

    logic [LB-1:0]       space;
    logic [LB-1:0]       clip_len;
    logic [LB-1:0]       cap_eff;
    logic                bump_ok;
    logic                mprev;
    logic                mnext;
    logic [LB:0]         prev_end;
    logic [LB:0]         this_end;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       pos_m1;
    logic [CW-1:0]       j_inc;
    logic [CW-1:0]       j_dec;

    assign space    = ffra_pkg::INDEX_SPACE - LB'(i_in_data.range_base);
    assign clip_len = (i_in_data.range_length > space) ? space : i_in_data.range_length;
    assign cap_eff  = (r_cap > ffra_pkg::INDEX_SPACE) ? ffra_pkg::INDEX_SPACE : r_cap;
    assign bump_ok  = (r_bump <= cap_eff) && (r_len <= cap_eff - r_bump);
    assign prev_end = {1'b0, LB'(r_prev.base)} + {1'b0, r_prev.len};
    assign this_end = {1'b0, LB'(r_base)} + {1'b0, r_len};
    assign mprev    = r_have_prev && (prev_end == {1'b0, LB'(r_base)});
    assign mnext    = r_have_next && (this_end == {1'b0, LB'(r_next.base)});
    assign idx_inc  = r_idx + CW'(1);
    assign pos_m1   = r_idx - CW'(1);
    assign j_inc    = r_j + CW'(1);
    assign j_dec    = r_j - CW'(1);

    // memory access, driven from the sequencer state
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[AW-1:0];
        case (r_state)
            S_DEC: begin
                if (mprev) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = pos_m1[AW-1:0];
                    o_mem_wdata.base = r_prev.base;
                    o_mem_wdata.len  = mnext ? (r_prev.len + r_len + r_next.len)
                                             : (r_prev.len + r_len);
                end else if (mnext) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata.base = r_base;
                    o_mem_wdata.len  = r_next.len + r_len;
                end
            end
            S_RM_RD:  o_mem_raddr = j_inc[AW-1:0];
            S_RM_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[AW-1:0];
            end
            S_INS_RD: begin
                o_mem_raddr = j_dec[AW-1:0];
                if (r_j <= r_idx) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata.base = r_base;
                    o_mem_wdata.len  = r_len;
                end
            end
            S_INS_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bump      <= '0;
            r_cap       <= ffra_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode      <= i_in_data.mode;
                        r_base      <= i_in_data.range_base;
                        r_len       <= (i_in_data.mode == ffra_pkg::MODE_FREE)
                                       ? clip_len : i_in_data.range_length;
                        r_idx       <= '0;
                        r_have_prev <= 1'b0;
                        r_have_next <= 1'b0;
                        if (i_in_data.range_length == '0) begin
                            r_res <= '{granted_base: '0, granted_length: '0,
                                       status: (i_in_data.mode == ffra_pkg::MODE_FREE)
                                               ? ffra_pkg::ST_OK
                                               : ffra_pkg::ST_NO_SPACE};
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_res   <= '0;
                            r_state <= S_DEC;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_EV;
                S_EV: begin
                    if (r_mode == ffra_pkg::MODE_ALLOC) begin
                        if (i_mem_rdata.len >= r_len) begin
                            r_res.granted_base   <= i_mem_rdata.base;
                            r_res.granted_length <= i_mem_rdata.len;
                            r_j     <= r_idx;
                            r_state <= S_RM_RD;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= (idx_inc == r_count) ? S_DEC : S_RD;
                        end
                    end else if (i_mem_rdata.base < r_base) begin
                        r_prev      <= i_mem_rdata;
                        r_have_prev <= 1'b1;
                        r_idx       <= idx_inc;
                        r_state     <= (idx_inc == r_count) ? S_DEC : S_RD;
                    end else begin
                        r_next      <= i_mem_rdata;
                        r_have_next <= 1'b1;
                        r_state     <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_mode == ffra_pkg::MODE_ALLOC) begin
                        // nothing in the table fits: fall back to the bump pointer
                        if (bump_ok) begin
                            r_res.granted_base   <= r_bump[IB-1:0];
                            r_res.granted_length <= r_len;
                            r_bump <= r_bump + r_len;
                        end else begin
                            r_res.status <= ffra_pkg::ST_NO_SPACE;
                        end
                        r_state <= S_DONE;
                    end else if (mprev && mnext) begin
                        r_j     <= r_idx;
                        r_state <= S_RM_RD;
                    end else if (mprev || mnext) begin
                        r_state <= S_DONE;
                    end else if (r_count >= SLOTS) begin
                        r_res.status <= ffra_pkg::ST_DROPPED;
                        r_state <= S_DONE;
                    end else begin
                        r_j     <= r_count;
                        r_state <= S_INS_RD;
                    end
                end
                S_RM_RD: begin
                    if (j_inc < r_count) begin
                        r_state <= S_RM_WR;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_RM_WR: begin
                    r_j     <= j_inc;
                    r_state <= S_RM_RD;
                end
                S_INS_RD: begin
                    // new entry is written here once the shift reaches its slot
                    if (r_j > r_idx) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_INS_WR: begin
                    r_j     <= j_dec;
                    r_state <= S_INS_RD;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
